// ----- design/bdeq_pkg.sv -----
// Shared types and constants for the bounded double-ended queue core.
// Used by bdeq_cell and bounded_double_ended_queue_core; depends on nothing.
package bdeq_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);

	localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK   = 3'd1;
	localparam logic [2:0] OP_DRAIN_FRONT = 3'd2;
	localparam logic [2:0] OP_DRAIN_BACK  = 3'd3;
	localparam logic [2:0] OP_LIST        = 3'd4;

	localparam logic [1:0] KIND_STORED = 2'd0;
	localparam logic [1:0] KIND_VALUE  = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;
	localparam logic [1:0] KIND_FULL   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FRONT = 4'b0010,
		ST_LIST  = 4'b0100,
		ST_BACK  = 4'b1000
	} state_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic take_left;
		logic take_right;
		logic rotate;
		logic append;
	} cell_ctrl_t;

endpackage

// ----- design/bdeq_cell.sv -----
// One storage cell of the queue chain: an element and its occupied bit.
// Depends on bdeq_pkg for the data width and the cell command struct.
module bdeq_cell
	import bdeq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [DATA_W-1:0] left_data,
	input  logic              left_valid,
	input  logic [DATA_W-1:0] right_data,
	input  logic              right_valid,
	input  logic [DATA_W-1:0] head_data,
	input  logic [DATA_W-1:0] value,
	output logic [DATA_W-1:0] data,
	output logic              valid
);

	logic [DATA_W-1:0] data_q;
	logic              valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			priority if (ctrl.take_left) begin
				valid_q <= left_valid;
			end else if (ctrl.take_right) begin
				valid_q <= right_valid;
			end else if (ctrl.append && !valid_q && left_valid) begin
				valid_q <= 1'b1;
			end else begin
				valid_q <= valid_q;
			end
		end
	end

	// During a listing the chain rotates: the last occupied cell takes the head.
	always_ff @(posedge clk) begin
		priority if (ctrl.take_left) begin
			data_q <= left_data;
		end else if (ctrl.take_right) begin
			data_q <= right_data;
		end else if (ctrl.rotate) begin
			data_q <= (valid_q && !right_valid) ? head_data : right_data;
		end else if (ctrl.append && !valid_q && left_valid) begin
			data_q <= value;
		end else begin
			data_q <= data_q;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

// ----- design/bounded_double_ended_queue_core.sv -----
// Top level of the bounded double-ended queue: control sequencer, output register
// and the chain of bdeq_cell storage cells. Depends on bdeq_pkg and bdeq_cell.

// The queue holds up to DEPTH signed 32-bit values in a row of cells, front in
// cell 0, packed toward it. A push gives one result, stored or full. Drain front
// and list emit one element per cycle from cell 0 while the output register is
// free, as the chain shifts or rotates. Drain back first shifts the chain toward
// the far end until the back element reaches the last cell, then emits one
// element per cycle from the last cell while the output register is free. A
// drain or list on an empty queue gives one empty result. A new transaction is
// taken only when the previous one has finished and the output register is free
// or being emptied; unused op codes are accepted and ignored.
module bounded_double_ended_queue_core
	import bdeq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        op,
	input  logic [DATA_W-1:0] value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        kind,
	output logic [DATA_W-1:0] value_res,
	output logic              last
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  rem_q, rem_d;
	cell_ctrl_t        ctrl;
	logic [DATA_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0]  cell_valid;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [DATA_W-1:0] value_res_q;
	logic              last_q;
	logic              out_free;
	logic              in_acc;
	logic              load_out;
	logic [1:0]        kind_d;
	logic [DATA_W-1:0] vres_d;
	logic              last_d;
	logic              at_last;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_acc   = in_valid && in_ready;
	assign at_last  = (rem_q == CNT_W'(1));

	genvar i;
	generate
		for (i = 0; i < DEPTH; i++) begin : g_cell
			logic [DATA_W-1:0] l_data, r_data;
			logic              l_valid, r_valid;
			if (i == 0) begin : g_first
				assign l_data  = value;
				assign l_valid = (state_q == ST_IDLE);
			end else begin : g_mid_l
				assign l_data  = cell_data[i-1];
				assign l_valid = cell_valid[i-1];
			end
			if (i == DEPTH - 1) begin : g_end
				assign r_data  = '0;
				assign r_valid = 1'b0;
			end else begin : g_mid_r
				assign r_data  = cell_data[i+1];
				assign r_valid = cell_valid[i+1];
			end
			bdeq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctrl        (ctrl),
				.left_data   (l_data),
				.left_valid  (l_valid),
				.right_data  (r_data),
				.right_valid (r_valid),
				.head_data   (cell_data[0]),
				.value       (value),
				.data        (cell_data[i]),
				.valid       (cell_valid[i])
			);
		end
	endgenerate

	always_comb begin
		ctrl     = '0;
		state_d  = state_q;
		count_d  = count_q;
		rem_d    = rem_q;
		load_out = 1'b0;
		kind_d   = KIND_STORED;
		vres_d   = '0;
		last_d   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					unique case (op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							load_out = 1'b1;
							if (count_q == CNT_W'(DEPTH)) begin
								kind_d = KIND_FULL;
							end else begin
								count_d = count_q + CNT_W'(1);
								if (op == OP_PUSH_FRONT) begin
									ctrl.take_left = 1'b1;
								end else begin
									ctrl.append = 1'b1;
								end
							end
						end
						OP_DRAIN_FRONT, OP_DRAIN_BACK, OP_LIST: begin
							if (count_q == '0) begin
								load_out = 1'b1;
								kind_d   = KIND_EMPTY;
							end else begin
								rem_d = count_q;
								if (op == OP_DRAIN_FRONT) begin
									state_d = ST_FRONT;
								end else if (op == OP_DRAIN_BACK) begin
									state_d = ST_BACK;
								end else begin
									state_d = ST_LIST;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_FRONT, ST_LIST: begin
				if (out_free) begin
					load_out = 1'b1;
					kind_d   = KIND_VALUE;
					vres_d   = cell_data[0];
					last_d   = at_last;
					rem_d    = rem_q - CNT_W'(1);
					if (state_q == ST_FRONT) begin
						ctrl.take_right = 1'b1;
					end else begin
						ctrl.rotate = 1'b1;
					end
					if (at_last) begin
						state_d = ST_IDLE;
						if (state_q == ST_FRONT) begin
							count_d = '0;
						end
					end
				end
			end
			ST_BACK: begin
				// Walk the back element out to the last cell before emitting.
				if (!cell_valid[DEPTH-1]) begin
					ctrl.take_left = 1'b1;
				end else if (out_free) begin
					ctrl.take_left = 1'b1;
					load_out       = 1'b1;
					kind_d         = KIND_VALUE;
					vres_d         = cell_data[DEPTH-1];
					last_d         = at_last;
					rem_d          = rem_q - CNT_W'(1);
					if (at_last) begin
						state_d = ST_IDLE;
						count_d = '0;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q      <= kind_d;
			value_res_q <= vres_d;
			last_q      <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value_res = value_res_q;
	assign last      = last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count exceeds the queue depth");

	a_count_matches_cells: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ($countones(cell_valid) == int'(count_q)))
		else $error("occupied cells disagree with the element count");

	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (rem_q != '0))
		else $error("emission in progress with nothing left to emit");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_d) |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after the final result");

endmodule

// ----- tb/sv/tb_bounded_double_ended_queue_core.sv -----
// Self-checking testbench for bounded_double_ended_queue_core: a table of directed
// transactions, then random push/drain/list traffic, each result checked against a
// ring-buffer predictor held in the testbench. Depends on bdeq_pkg and the core.
module tb_bounded_double_ended_queue_core;
	import bdeq_pkg::*;

	localparam logic [2:0] OP_RESERVED_LO = 3'd5;
	localparam logic [2:0] OP_RESERVED_MID = 3'd6;
	localparam logic [2:0] OP_RESERVED_HI = 3'd7;
	localparam int RANDOM_ITEMS = 200;

	typedef struct packed {
		logic [1:0]        kind;
		logic [DATA_W-1:0] value;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [2:0]        op;
		logic [DATA_W-1:0] value;
		logic [7:0]        reps;
		logic              typed;
		logic [1:0]        kind;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [2:0]        op;
	logic [DATA_W-1:0] value;
	logic              out_valid;
	logic              out_ready;
	logic [1:0]        kind;
	logic [DATA_W-1:0] value_res;
	logic              last;

	// Predictor state: ring buffer with head position and fill level.
	logic [DATA_W-1:0] deque_mem [DEPTH];
	int                deque_head;
	int                deque_len;

	result_t   pending_results[$];
	stim_row_t plan[$];
	int        fail_count;
	bit        tx_calm;
	bit        rx_calm;

	bounded_double_ended_queue_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.value_res (value_res),
		.last      (last)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= 100)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	function automatic int idle_cycles(input bit calm);
		return calm ? 0 : int'($urandom_range(0, 8));
	endfunction

	task automatic expect_contents(input bit reverse);
		int idx;
		if (deque_len == 0) begin
			pending_results.push_back('{KIND_EMPTY, '0, 1'b1});
		end else begin
			for (int i = 0; i < deque_len; i++) begin
				idx = reverse ? deque_len - 1 - i : i;
				pending_results.push_back('{KIND_VALUE,
					deque_mem[(deque_head + idx) % DEPTH], i == deque_len - 1});
			end
		end
	endtask

	// Advances the predictor by one accepted transaction; with record clear the
	// state moves on but the results are left to the caller.
	task automatic model_deque_op(input logic [2:0] cmd, input logic [DATA_W-1:0] operand,
			input bit record);
		result_t res;
		case (cmd)
		OP_PUSH_FRONT, OP_PUSH_BACK: begin
			if (deque_len == DEPTH) begin
				res = '{KIND_FULL, '0, 1'b1};
			end else begin
				if (cmd == OP_PUSH_FRONT) begin
					deque_head = (deque_head + DEPTH - 1) % DEPTH;
					deque_mem[deque_head] = operand;
				end else begin
					deque_mem[(deque_head + deque_len) % DEPTH] = operand;
				end
				deque_len++;
				res = '{KIND_STORED, '0, 1'b1};
			end
			if (record)
				pending_results.push_back(res);
		end
		OP_DRAIN_FRONT, OP_DRAIN_BACK: begin
			if (record)
				expect_contents(cmd == OP_DRAIN_BACK);
			deque_len = 0;
		end
		OP_LIST: begin
			if (record)
				expect_contents(1'b0);
		end
		default: begin
		end
		endcase
	endtask

	// Presents one transaction and returns at the edge where it is accepted.
	task automatic send_item(input logic [2:0] cmd, input logic [DATA_W-1:0] operand,
			input bit record);
		int gap;
		if ($urandom_range(0, 29) == 0)
			tx_calm = !tx_calm;
		gap = idle_cycles(tx_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= cmd;
		value <= operand;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		model_deque_op(cmd, operand, record);
	endtask

	function automatic void add_row(input logic [2:0] cmd, input logic [DATA_W-1:0] operand,
			input int reps, input bit typed, input logic [1:0] res_kind);
		plan.push_back('{cmd, operand, reps[7:0], typed, res_kind});
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result kind %0d value %0d last %0b",
					kind, $signed(value_res), last));
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
				if (value_res !== want.value)
					report_mismatch($sformatf("value_res %0d, expected %0d",
						$signed(value_res), $signed(want.value)));
				if (last !== want.last)
					report_mismatch($sformatf("last %0b, expected %0b", last, want.last));
			end
		end
	end

	// Result side: out_ready is held low for a random gap before each result is taken.
	initial begin
		int gap;
		out_ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_calm = !rx_calm;
			gap = idle_cycles(rx_calm);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [2:0]        cmd;
		logic [DATA_W-1:0] word;
		int                sent;
		int                fill_left;
		int                pick;
		bit                paused;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_PUSH_FRONT;
		value <= '0;
		fail_count = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		deque_head = 0;
		deque_len = 0;

		// Empty queue first, then the value extremes, unused codes, a single
		// element drained from the back, filling to full from both ends with the
		// head wrapping, and pushes refused while full.
		add_row(OP_DRAIN_FRONT, 32'h0000_0000, 1, 1'b1, KIND_EMPTY);
		add_row(OP_DRAIN_BACK, 32'hffff_ffff, 1, 1'b1, KIND_EMPTY);
		add_row(OP_LIST, 32'h0000_0000, 1, 1'b1, KIND_EMPTY);
		add_row(OP_PUSH_BACK, 32'h7fff_ffff, 1, 1'b1, KIND_STORED);
		add_row(OP_PUSH_FRONT, 32'h8000_0000, 1, 1'b1, KIND_STORED);
		add_row(OP_PUSH_BACK, 32'hffff_ffff, 1, 1'b1, KIND_STORED);
		add_row(OP_PUSH_FRONT, 32'h0000_0000, 1, 1'b1, KIND_STORED);
		add_row(OP_LIST, 32'h0000_0000, 1, 1'b0, KIND_VALUE);
		add_row(OP_RESERVED_LO, 32'h1234_5678, 1, 1'b0, KIND_VALUE);
		add_row(OP_RESERVED_MID, 32'hffff_ffff, 1, 1'b0, KIND_VALUE);
		add_row(OP_RESERVED_HI, 32'h0000_0000, 1, 1'b0, KIND_VALUE);
		add_row(OP_DRAIN_BACK, 32'h0000_0000, 1, 1'b0, KIND_VALUE);
		add_row(OP_LIST, 32'h0000_0000, 1, 1'b1, KIND_EMPTY);
		add_row(OP_PUSH_FRONT, 32'h5a5a_5a5a, 1, 1'b1, KIND_STORED);
		add_row(OP_DRAIN_BACK, 32'h0000_0000, 1, 1'b0, KIND_VALUE);
		add_row(OP_PUSH_BACK, 32'h1357_9bdf, 1, 1'b1, KIND_STORED);
		add_row(OP_DRAIN_FRONT, 32'h0000_0000, 1, 1'b0, KIND_VALUE);
		add_row(OP_PUSH_BACK, 32'h1000_0000, DEPTH, 1'b1, KIND_STORED);
		add_row(OP_PUSH_FRONT, 32'haaaa_aaaa, 1, 1'b1, KIND_FULL);
		add_row(OP_PUSH_BACK, 32'h5555_5555, 1, 1'b1, KIND_FULL);
		add_row(OP_LIST, 32'h0000_0000, 1, 1'b0, KIND_VALUE);
		add_row(OP_DRAIN_BACK, 32'h0000_0000, 1, 1'b0, KIND_VALUE);
		add_row(OP_PUSH_FRONT, 32'hf000_0000, DEPTH, 1'b1, KIND_STORED);
		add_row(OP_PUSH_BACK, 32'h0000_0001, 1, 1'b1, KIND_FULL);
		add_row(OP_DRAIN_FRONT, 32'h0000_0000, 1, 1'b0, KIND_VALUE);
		add_row(OP_DRAIN_FRONT, 32'h0000_0000, 1, 1'b1, KIND_EMPTY);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[r]) begin
			for (int k = 0; k < plan[r].reps; k++) begin
				send_item(plan[r].op, plan[r].value + k, !plan[r].typed);
				if (plan[r].typed)
					pending_results.push_back('{plan[r].kind, '0, 1'b1});
			end
		end

		// Random traffic leans on pushes so the queue holds something worth
		// draining; now and then a burst of pushes runs it into the full case.
		sent = 0;
		fill_left = 0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (!paused && sent >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				in_valid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (fill_left > 0) begin
				cmd = pick[0] ? OP_PUSH_FRONT : OP_PUSH_BACK;
				fill_left--;
			end else if (pick < 3) begin
				cmd = OP_PUSH_BACK;
				fill_left = DEPTH + 4;
			end else if (pick < 37) begin
				cmd = OP_PUSH_FRONT;
			end else if (pick < 70) begin
				cmd = OP_PUSH_BACK;
			end else if (pick < 78) begin
				cmd = OP_DRAIN_FRONT;
			end else if (pick < 86) begin
				cmd = OP_DRAIN_BACK;
			end else if (pick < 95) begin
				cmd = OP_LIST;
			end else begin
				cmd = 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
			end
			case ($urandom_range(0, 7))
			0: word = 32'h8000_0000;
			1: word = 32'h7fff_ffff;
			2: word = '0;
			3: word = '1;
			default: word = $urandom();
			endcase
			send_item(cmd, word, 1'b1);
			if (cmd <= OP_LIST)
				sent++;
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (2 * DEPTH + 16) @(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
